FILE: hdl/spmq_pkg.sv
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types and constants of the strict priority multi-queue unit.
// ----------------------------------------------------------------------------
package spmq_pkg;

   localparam int LEVELS      = 5;
   localparam int QUEUE_DEPTH = 16;

   localparam int OPCODE_W = 2;
   localparam int LEVEL_W  = 3;
   localparam int ID_W     = 16;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 32;
   localparam int SUM_W    = 48;

   localparam int LVL_IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int ENTRY_W   = ID_W + TIME_W;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_STATS   = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 2'd0,
      ST_INVALID_LEVEL = 2'd1,
      ST_QUEUE_FULL    = 2'd2,
      ST_ALL_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [LEVEL_W-1:0]  level;
      logic [ID_W-1:0]     entry_id;
      logic [TIME_W-1:0]   arrival_time;
      logic [TIME_W-1:0]   current_time;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     served_id;
      logic [LEVEL_W-1:0]  served_level;
      logic [TIME_W-1:0]   wait_seconds;
      logic [COUNT_W-1:0]  enqueued_count;
      logic [COUNT_W-1:0]  served_count;
      logic [SUM_W-1:0]    wait_sum;
   } rsp_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // request transfer: latch payload, start entry read
      logic execute;     // decode and update queue state
      logic accumulate;  // add wait into the level's wait sum
      logic load_out;    // load the result register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic deq_hit;     // latched request is a dequeue with an entry to serve
   } dp_stat_type;

endpackage

FILE: hdl/spmq_req_if.sv
// ----------------------------------------------------------------------------
// spmq_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface spmq_req_if;
   logic                            valid;
   logic                            ready;
   logic [spmq_pkg::OPCODE_W-1:0]   opcode;
   logic [spmq_pkg::LEVEL_W-1:0]    level;
   logic [spmq_pkg::ID_W-1:0]       entry_id;
   logic [spmq_pkg::TIME_W-1:0]     arrival_time;
   logic [spmq_pkg::TIME_W-1:0]     current_time;

   modport source (output valid, opcode, level, entry_id, arrival_time, current_time,
                   input ready);
   modport sink   (input valid, opcode, level, entry_id, arrival_time, current_time,
                   output ready);
endinterface

// ----------------------------------------------------------------------------
// spmq_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface spmq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [spmq_pkg::STATUS_W-1:0]   status;
   logic [spmq_pkg::ID_W-1:0]       served_id;
   logic [spmq_pkg::LEVEL_W-1:0]    served_level;
   logic [spmq_pkg::TIME_W-1:0]     wait_seconds;
   logic [spmq_pkg::COUNT_W-1:0]    enqueued_count;
   logic [spmq_pkg::COUNT_W-1:0]    served_count;
   logic [spmq_pkg::SUM_W-1:0]      wait_sum;

   modport source (output valid, status, served_id, served_level, wait_seconds,
                          enqueued_count, served_count, wait_sum,
                   input ready);
   modport sink   (input valid, status, served_id, served_level, wait_seconds,
                         enqueued_count, served_count, wait_sum,
                   output ready);
endinterface

FILE: hdl/strict_priority_multi_queue_unit.sv
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_unit
// Five-level strict priority FIFO queue with per-level statistics.
// ----------------------------------------------------------------------------
// One request is worked at a time and each gives exactly one result. An
// enqueue, a statistics read, an opcode 3 or a dequeue that finds every queue
// empty goes from the capture registers through the execute state into the
// result register; a dequeue that serves an entry also passes through the
// accumulate state. Capture does the registered read of the entry memory at
// the head of the most urgent non-empty level, and the accumulate state does
// the saturating 48-bit wait-sum add. A new request is taken while the
// previous result waits, as long as that result leaves by the same edge. The
// entry memory is not cleared; after reset the unit is ready at once. Waits
// are whole seconds; conversion and averaging are for software.
module strict_priority_multi_queue_unit (
   input  logic       clock,
   input  logic       reset,
   spmq_req_if.sink   req_chan,
   spmq_rsp_if.source rsp_chan
);

   spmq_pkg::ctrl_cmd_type    cmd;
   spmq_pkg::dp_stat_type     dp_stat;
   spmq_pkg::req_payload_type req_payload;
   spmq_pkg::rsp_payload_type rsp_payload;

   assign req_payload.opcode       = req_chan.opcode;
   assign req_payload.level        = req_chan.level;
   assign req_payload.entry_id     = req_chan.entry_id;
   assign req_payload.arrival_time = req_chan.arrival_time;
   assign req_payload.current_time = req_chan.current_time;

   spmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   spmq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .dp_stat     (dp_stat),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

   assign rsp_chan.status         = rsp_payload.status;
   assign rsp_chan.served_id      = rsp_payload.served_id;
   assign rsp_chan.served_level   = rsp_payload.served_level;
   assign rsp_chan.wait_seconds   = rsp_payload.wait_seconds;
   assign rsp_chan.enqueued_count = rsp_payload.enqueued_count;
   assign rsp_chan.served_count   = rsp_payload.served_count;
   assign rsp_chan.wait_sum       = rsp_payload.wait_sum;

   // a request transfer frees the result register by the next cycle
   a_accept_clears_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !rsp_chan.valid)
      else $error("result pending right after request transfer");

   // one request in flight at a time
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second request taken while one is in flight");

   // only a served dequeue reports an id or a wait
   a_fail_fields_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != spmq_pkg::ST_OK))
         |-> (rsp_chan.served_id == '0) && (rsp_chan.wait_seconds == '0)
             && (rsp_chan.wait_sum == '0))
      else $error("failed request carries result data");

   // a result is loaded only into an empty result register
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out) |-> (!rsp_chan.valid))
      else $error("result register overwritten");

endmodule

FILE: hdl/spmq_ctrl.sv
// ----------------------------------------------------------------------------
// spmq_ctrl
// Sequencer: takes one request at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module spmq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  spmq_pkg::dp_stat_type  dp_stat,
   output spmq_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_ACCUM
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // a new request only when the result register is free or drains this cycle
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      state_in       = state_ff;
      cmd.capture    = req_valid && req_ready;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            if (dp_stat.deq_hit) begin
               state_in = S_ACCUM;
            end else begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_ACCUM: begin
            cmd.accumulate = 1'b1;
            cmd.load_out   = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/spmq_datapath.sv
// ----------------------------------------------------------------------------
// spmq_datapath
// Entry memory, per-level queue pointers and statistics, result register.
// ----------------------------------------------------------------------------
module spmq_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  spmq_pkg::ctrl_cmd_type    cmd,
   output spmq_pkg::dp_stat_type     dp_stat,
   input  spmq_pkg::req_payload_type req_payload,
   output spmq_pkg::rsp_payload_type rsp_payload
);

   localparam int LVL_CMP_W = spmq_pkg::LEVEL_W + 1;

   // entry memory: id in the upper bits, arrival time in the lower bits
   logic [spmq_pkg::ENTRY_W-1:0] entry_mem [spmq_pkg::MEM_DEPTH];
   logic [spmq_pkg::ENTRY_W-1:0] rd_data_ff;

   // per-level queue state
   logic [spmq_pkg::PTR_W-1:0]   head_ff  [spmq_pkg::LEVELS];
   logic [spmq_pkg::PTR_W-1:0]   tail_ff  [spmq_pkg::LEVELS];
   logic [spmq_pkg::FILL_W-1:0]  fill_ff  [spmq_pkg::LEVELS];
   logic [spmq_pkg::COUNT_W-1:0] enq_ff   [spmq_pkg::LEVELS];
   logic [spmq_pkg::COUNT_W-1:0] srv_ff   [spmq_pkg::LEVELS];
   logic [spmq_pkg::SUM_W-1:0]   wsum_ff  [spmq_pkg::LEVELS];

   spmq_pkg::req_payload_type    req_ff;
   logic [spmq_pkg::LVL_IDX_W-1:0] sel_ff, sel_in;
   logic                         any_ff, any_in;
   logic [spmq_pkg::TIME_W-1:0]  wait_ff, wait_in;
   spmq_pkg::rsp_payload_type    out_ff, out_in;

   logic [spmq_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
   logic                         lvl_valid;
   logic [spmq_pkg::LVL_IDX_W-1:0] q_idx;
   logic                         q_full;
   logic                         enq_ok;
   logic [spmq_pkg::TIME_W-1:0]  arr_time;
   logic [spmq_pkg::SUM_W:0]     sum_wide;
   logic [spmq_pkg::SUM_W-1:0]   sum_sat;
   spmq_pkg::rsp_payload_type    exec_rsp, acc_rsp;

   function automatic logic [spmq_pkg::PTR_W-1:0] next_slot(
      input logic [spmq_pkg::PTR_W-1:0] ptr
   );
      logic [spmq_pkg::PTR_W:0] inc;
      inc = {1'b0, ptr} + 1'b1;
      if (inc >= (spmq_pkg::PTR_W + 1)'(spmq_pkg::QUEUE_DEPTH)) begin
         return '0;
      end
      return inc[spmq_pkg::PTR_W-1:0];
   endfunction

   function automatic logic [spmq_pkg::COUNT_W-1:0] sat_inc(
      input logic [spmq_pkg::COUNT_W-1:0] cnt
   );
      return (&cnt) ? cnt : cnt + 1'b1;
   endfunction

   function automatic logic [spmq_pkg::ADDR_W-1:0] slot_addr(
      input logic [spmq_pkg::LVL_IDX_W-1:0] lvl,
      input logic [spmq_pkg::PTR_W-1:0]     ptr
   );
      return spmq_pkg::ADDR_W'(lvl) * spmq_pkg::ADDR_W'(spmq_pkg::QUEUE_DEPTH)
             + spmq_pkg::ADDR_W'(ptr);
   endfunction

   // lowest-numbered non-empty level, looked up at request transfer
   always_comb begin
      sel_in = '0;
      any_in = 1'b0;
      for (int i = spmq_pkg::LEVELS - 1; i >= 0; i--) begin
         if (fill_ff[i] != '0) begin
            sel_in = spmq_pkg::LVL_IDX_W'(i);
            any_in = 1'b1;
         end
      end
   end

   assign rd_addr = slot_addr(sel_in, head_ff[sel_in]);

   assign lvl_valid = (req_ff.level != '0) &&
                      (LVL_CMP_W'(req_ff.level) <= LVL_CMP_W'(spmq_pkg::LEVELS));
   // parked on level 0 when the level is out of range
   assign q_idx   = lvl_valid ? spmq_pkg::LVL_IDX_W'(req_ff.level - 1'b1) : '0;
   assign q_full  = (fill_ff[q_idx] >= spmq_pkg::FILL_W'(spmq_pkg::QUEUE_DEPTH));
   assign enq_ok  = cmd.execute && (spmq_pkg::opcode_type'(req_ff.opcode) == spmq_pkg::OP_ENQUEUE)
                    && lvl_valid && !q_full;
   assign wr_addr = slot_addr(q_idx, tail_ff[q_idx]);

   assign dp_stat.deq_hit = (spmq_pkg::opcode_type'(req_ff.opcode) == spmq_pkg::OP_DEQUEUE)
                            && any_ff;

   // wait: current time minus arrival, clamped at zero
   assign arr_time = rd_data_ff[spmq_pkg::TIME_W-1:0];
   assign wait_in  = (req_ff.current_time >= arr_time) ? req_ff.current_time - arr_time : '0;

   assign sum_wide = {1'b0, wsum_ff[sel_ff]} + (spmq_pkg::SUM_W + 1)'(wait_ff);
   assign sum_sat  = sum_wide[spmq_pkg::SUM_W] ? '1 : sum_wide[spmq_pkg::SUM_W-1:0];

   always_comb begin
      exec_rsp = '0;
      case (spmq_pkg::opcode_type'(req_ff.opcode))
         spmq_pkg::OP_ENQUEUE: begin
            if (!lvl_valid) begin
               exec_rsp.status = spmq_pkg::ST_INVALID_LEVEL;
            end else if (q_full) begin
               exec_rsp.status = spmq_pkg::ST_QUEUE_FULL;
            end else begin
               exec_rsp.status = spmq_pkg::ST_OK;
            end
         end
         spmq_pkg::OP_DEQUEUE: begin
            exec_rsp.status = spmq_pkg::ST_ALL_EMPTY;
         end
         spmq_pkg::OP_STATS: begin
            if (!lvl_valid) begin
               exec_rsp.status = spmq_pkg::ST_INVALID_LEVEL;
            end else begin
               exec_rsp.status         = spmq_pkg::ST_OK;
               exec_rsp.served_level   = req_ff.level;
               exec_rsp.enqueued_count = enq_ff[q_idx];
               exec_rsp.served_count   = srv_ff[q_idx];
               exec_rsp.wait_sum       = wsum_ff[q_idx];
            end
         end
         spmq_pkg::OP_NOP: begin
            exec_rsp.status = spmq_pkg::ST_OK;
         end
         default: begin
            exec_rsp.status = spmq_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      acc_rsp                = '0;
      acc_rsp.status         = spmq_pkg::ST_OK;
      acc_rsp.served_id      = rd_data_ff[spmq_pkg::ENTRY_W-1:spmq_pkg::TIME_W];
      acc_rsp.served_level   = spmq_pkg::LEVEL_W'(sel_ff + 1'b1);
      acc_rsp.wait_seconds   = wait_ff;
      acc_rsp.enqueued_count = enq_ff[sel_ff];
      acc_rsp.served_count   = srv_ff[sel_ff];
      acc_rsp.wait_sum       = sum_sat;
   end

   assign out_in      = cmd.accumulate ? acc_rsp : exec_rsp;
   assign rsp_payload = out_ff;

   // entry memory, no reset
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
      if (enq_ok) begin
         entry_mem[wr_addr] <= {req_ff.entry_id, req_ff.arrival_time};
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
         sel_ff <= sel_in;
         any_ff <= any_in;
      end
      if (cmd.execute && dp_stat.deq_hit) begin
         wait_ff <= wait_in;
      end
      if (cmd.load_out) begin
         out_ff <= out_in;
      end
   end

   // queue pointers and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < spmq_pkg::LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
            enq_ff[i]  <= '0;
            srv_ff[i]  <= '0;
            wsum_ff[i] <= '0;
         end
      end else begin
         if (enq_ok) begin
            tail_ff[q_idx] <= next_slot(tail_ff[q_idx]);
            fill_ff[q_idx] <= fill_ff[q_idx] + 1'b1;
            enq_ff[q_idx]  <= sat_inc(enq_ff[q_idx]);
         end
         if (cmd.execute && dp_stat.deq_hit) begin
            head_ff[sel_ff] <= next_slot(head_ff[sel_ff]);
            fill_ff[sel_ff] <= fill_ff[sel_ff] - 1'b1;
            srv_ff[sel_ff]  <= sat_inc(srv_ff[sel_ff]);
         end
         if (cmd.accumulate) begin
            wsum_ff[sel_ff] <= sum_sat;
         end
      end
   end

endmodule

FILE: sim/spmq_checker.sv
// ----------------------------------------------------------------------------
// spmq_checker
// Watches the request and result channels of the priority queue unit. It keeps
// its own copy of the five queues and their statistics, works out the result
// of every request transfer and compares each result transfer with the oldest
// result still owed.
// ----------------------------------------------------------------------------
module spmq_checker
   import spmq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   spmq_req_if         req_mon,
   spmq_rsp_if         rsp_mon,
   output int unsigned mismatches,
   output int unsigned pending,
   output int unsigned results_checked,
   output int unsigned served_hits,
   output int unsigned full_rejects,
   output int unsigned invalid_rejects,
   output int unsigned empty_hits,
   output bit          sum_saturated
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

   // queue contents and per-level statistics
   logic [ID_W-1:0]    slot_id      [LEVELS][QUEUE_DEPTH];
   logic [TIME_W-1:0]  slot_arrival [LEVELS][QUEUE_DEPTH];
   int                 head_at      [LEVELS];
   int                 tail_at      [LEVELS];
   int                 depth_now    [LEVELS];
   logic [COUNT_W-1:0] enq_tally    [LEVELS];
   logic [COUNT_W-1:0] srv_tally    [LEVELS];
   logic [SUM_W-1:0]   wait_tally   [LEVELS];

   rsp_payload_type owed_results[$];
   rsp_payload_type want;
   req_payload_type arrived;

   function automatic rsp_payload_type serve_request(req_payload_type r);
      rsp_payload_type res;
      int              q;
      bit              found;
      bit              lvl_ok;
      logic [TIME_W-1:0] waited;
      logic [SUM_W:0]    grown;
      res    = '0;
      q      = 0;
      found  = 1'b0;
      lvl_ok = (r.level >= 1) && (r.level <= LEVELS);
      case (opcode_type'(r.opcode))
         OP_ENQUEUE: begin
            if (!lvl_ok) begin
               res.status = ST_INVALID_LEVEL;
               invalid_rejects++;
            end else begin
               q = r.level - 1;
               if (depth_now[q] >= QUEUE_DEPTH) begin
                  res.status = ST_QUEUE_FULL;
                  full_rejects++;
               end else begin
                  slot_id[q][tail_at[q]]      = r.entry_id;
                  slot_arrival[q][tail_at[q]] = r.arrival_time;
                  tail_at[q]   = (tail_at[q] + 1) % QUEUE_DEPTH;
                  depth_now[q] = depth_now[q] + 1;
                  if (enq_tally[q] != COUNT_MAX) enq_tally[q]++;
               end
            end
         end
         OP_DEQUEUE: begin
            for (int k = 0; k < LEVELS; k++) begin
               if (!found && depth_now[k] != 0) begin
                  found = 1'b1;
                  q     = k;
               end
            end
            if (!found) begin
               res.status = ST_ALL_EMPTY;
               empty_hits++;
            end else begin
               // late arrival stamps give a zero wait, never a negative one
               waited = (r.current_time >= slot_arrival[q][head_at[q]]) ?
                        r.current_time - slot_arrival[q][head_at[q]] : '0;
               res.served_id    = slot_id[q][head_at[q]];
               res.served_level = LEVEL_W'(q + 1);
               res.wait_seconds = waited;
               head_at[q]   = (head_at[q] + 1) % QUEUE_DEPTH;
               depth_now[q] = depth_now[q] - 1;
               if (srv_tally[q] != COUNT_MAX) srv_tally[q]++;
               grown = {1'b0, wait_tally[q]} + waited;
               wait_tally[q] = (grown > SUM_MAX) ? SUM_MAX : grown[SUM_W-1:0];
               if (wait_tally[q] == SUM_MAX) sum_saturated = 1'b1;
               res.enqueued_count = enq_tally[q];
               res.served_count   = srv_tally[q];
               res.wait_sum       = wait_tally[q];
               served_hits++;
            end
         end
         OP_STATS: begin
            if (!lvl_ok) begin
               res.status = ST_INVALID_LEVEL;
               invalid_rejects++;
            end else begin
               q = r.level - 1;
               res.served_level   = r.level;
               res.enqueued_count = enq_tally[q];
               res.served_count   = srv_tally[q];
               res.wait_sum       = wait_tally[q];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LEVELS; k++) begin
            head_at[k]    = 0;
            tail_at[k]    = 0;
            depth_now[k]  = 0;
            enq_tally[k]  = '0;
            srv_tally[k]  = '0;
            wait_tally[k] = '0;
         end
         owed_results.delete();
         mismatches      = 0;
         results_checked = 0;
         served_hits     = 0;
         full_rejects    = 0;
         invalid_rejects = 0;
         empty_hits      = 0;
         sum_saturated   = 1'b0;
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (owed_results.size() == 0) begin
               $error("result transfer with no request outstanding");
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               results_checked++;
               check_field("status",         want.status,         rsp_mon.status);
               check_field("served_id",      want.served_id,      rsp_mon.served_id);
               check_field("served_level",   want.served_level,   rsp_mon.served_level);
               check_field("wait_seconds",   want.wait_seconds,   rsp_mon.wait_seconds);
               check_field("enqueued_count", want.enqueued_count, rsp_mon.enqueued_count);
               check_field("served_count",   want.served_count,   rsp_mon.served_count);
               check_field("wait_sum",       want.wait_sum,       rsp_mon.wait_sum);
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            arrived = {req_mon.opcode, req_mon.level, req_mon.entry_id,
                       req_mon.arrival_time, req_mon.current_time};
            owed_results.push_back(serve_request(arrived));
         end
      end
      pending = owed_results.size();
   end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the strict priority multi-queue unit: a directed opening over
// the edge cases, random episodes that fill and drain the queues under three
// idle patterns, and a short run of maximal waits served on one level.
// Results are checked by spmq_checker.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spmq_pkg::*;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_type;

   localparam int RANDOM_PER_PHASE = 230;
   localparam int LONG_WAIT_PAIRS  = 24;

   logic clock;
   logic reset;

   spmq_req_if req_chan();
   spmq_rsp_if rsp_chan();

   int unsigned check_errors;
   int unsigned pending;
   int unsigned results_checked;
   int unsigned served_hits;
   int unsigned full_rejects;
   int unsigned invalid_rejects;
   int unsigned empty_hits;
   bit          sum_saturated;

   int                send_gap_pct = 31;
   int                hold_pct     = 55;
   logic [LEVEL_W-1:0] focus_level  = 3'd1;
   logic [TIME_W-1:0]  wall_seconds;

   strict_priority_multi_queue_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   spmq_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatches      (check_errors),
      .pending         (pending),
      .results_checked (results_checked),
      .served_hits     (served_hits),
      .full_rejects    (full_rejects),
      .invalid_rejects (invalid_rejects),
      .empty_hits      (empty_hits),
      .sum_saturated   (sum_saturated)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= hold_pct);
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_request(input req_payload_type p);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.opcode       <= p.opcode;
      req_chan.level        <= p.level;
      req_chan.entry_id     <= p.entry_id;
      req_chan.arrival_time <= p.arrival_time;
      req_chan.current_time <= p.current_time;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_payload_type random_request(mix_type mix);
      req_payload_type r;
      int pick;
      pick = $urandom_range(99);
      case (mix)
         MIX_FILL:  r.opcode = pick < 80 ? OP_ENQUEUE : pick < 92 ? OP_DEQUEUE :
                               pick < 97 ? OP_STATS : OP_NOP;
         MIX_DRAIN: r.opcode = pick < 15 ? OP_ENQUEUE : pick < 88 ? OP_DEQUEUE :
                               pick < 96 ? OP_STATS : OP_NOP;
         default:   r.opcode = pick < 45 ? OP_ENQUEUE : pick < 85 ? OP_DEQUEUE :
                               pick < 95 ? OP_STATS : OP_NOP;
      endcase
      if ($urandom_range(99) < 8)
         r.level = ($urandom_range(2) == 0) ? 3'd0 : LEVEL_W'($urandom_range(LEVELS + 1, 7));
      else if (mix == MIX_FILL && $urandom_range(99) < 60)
         r.level = focus_level;
      else
         r.level = LEVEL_W'($urandom_range(1, LEVELS));
      r.entry_id = ID_W'($urandom_range(16'hFFFF));
      // mostly a running clock with arrivals in the recent past, some raw noise
      wall_seconds = wall_seconds + $urandom_range(900);
      r.arrival_time = ($urandom_range(99) < 75) ? wall_seconds - $urandom_range(3600)
                                                 : $urandom();
      r.current_time = ($urandom_range(99) < 85) ? wall_seconds : $urandom();
      return r;
   endfunction

   initial begin
      int sent;
      int span;
      mix_type mix;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.opcode       = '0;
      req_chan.level        = '0;
      req_chan.entry_id     = '0;
      req_chan.arrival_time = '0;
      req_chan.current_time = '0;
      rsp_chan.ready        = 1'b0;
      wall_seconds          = $urandom();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening
      send_request({OP_DEQUEUE, 3'd0, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF});
      send_request({OP_STATS,   3'd0, 16'h0000, 32'h0000_0000, 32'h0000_0000});
      send_request({OP_STATS,   3'd7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_request({OP_ENQUEUE, 3'd6, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000});
      send_request({OP_NOP,     3'd7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_request({OP_ENQUEUE, 3'd1, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000});
      // one past the depth so the last one bounces off a full queue
      for (int k = 0; k <= QUEUE_DEPTH; k++)
         send_request({OP_ENQUEUE, 3'd5, ID_W'(k), 32'h0000_0000, 32'h0000_0000});
      send_request({OP_DEQUEUE, 3'd0, 16'h0000, 32'h0000_0000, 32'h0000_0000});
      send_request({OP_DEQUEUE, 3'd0, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF});
      send_request({OP_STATS,   3'd5, 16'h0000, 32'h0000_0000, 32'h0000_0000});

      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = (phase == 0) ? 31 : (phase == 1) ? 55 : 0;
         hold_pct     = (phase == 0) ? 55 : (phase == 1) ? 31 : 0;
         sent = 0;
         while (sent < RANDOM_PER_PHASE) begin
            mix         = mix_type'($urandom_range(2));
            focus_level = LEVEL_W'($urandom_range(1, LEVELS));
            span        = $urandom_range(30, 60);
            for (int k = 0; k < span; k++)
               send_request(random_request(mix));
            sent += span;
         end
      end

      // empty every queue, then serve maximal waits on one level
      for (int k = 0; k < LEVELS * QUEUE_DEPTH; k++)
         send_request({OP_DEQUEUE, 3'd0, 16'h0000, 32'h0000_0000, 32'h0000_0000});
      for (int k = 0; k < LONG_WAIT_PAIRS; k++) begin
         send_request({OP_ENQUEUE, LEVEL_W'(LEVELS), ID_W'($urandom_range(16'hFFFF)),
                       32'h0000_0000, 32'h0000_0000});
         send_request({OP_DEQUEUE, 3'd0, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF});
      end
      send_request({OP_STATS, LEVEL_W'(LEVELS), 16'h0000, 32'h0000_0000, 32'h0000_0000});
      req_chan.valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      $display("Covered %0d results: %0d entries served, %0d full-queue and %0d bad-level rejects,",
               results_checked, served_hits, full_rejects, invalid_rejects);
      $display("%0d dequeues with every queue empty; wait-sum saturation %s.",
               empty_hits, sum_saturated ? "reached" : "not reached");
      if (check_errors == 0) begin
         $display("[strict_priority_multi_queue_unit] OK");
      end else begin
         $display("[strict_priority_multi_queue_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d results still outstanding", pending);
      $display("[strict_priority_multi_queue_unit] ERROR");
      $finish;
   end

endmodule
